// ===== sv/rvis_pkg.sv =====
// rvis_pkg: shared types, codes and constants of the RV64IM instruction step.
// No dependencies; rvis_muldiv, the step module and the testbench take their names from here.
package rvis_pkg;

   localparam logic [63:0] MEM_BYTES  = 64'd262144;
   localparam logic [63:0] DATA_START = 64'd65536;
   localparam int XLEN      = 64;
   localparam int REG_COUNT = 32;
   localparam int REG_IDX_W = 5;
   localparam int ADDR_W    = 18;

   // Major opcodes
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;
   localparam logic [6:0] F7_MULD = 7'h01;

   // Multiply/divide function codes (funct3)
   localparam logic [2:0] MD_MUL    = 3'd0;
   localparam logic [2:0] MD_MULH   = 3'd1;
   localparam logic [2:0] MD_MULHSU = 3'd2;
   localparam logic [2:0] MD_MULHU  = 3'd3;
   localparam logic [2:0] MD_DIV    = 3'd4;
   localparam logic [2:0] MD_DIVU   = 3'd5;
   localparam logic [2:0] MD_REM    = 3'd6;
   localparam logic [2:0] MD_REMU   = 3'd7;

   // Load kinds (funct3)
   localparam logic [2:0] LD_B  = 3'd0;
   localparam logic [2:0] LD_H  = 3'd1;
   localparam logic [2:0] LD_W  = 3'd2;
   localparam logic [2:0] LD_BU = 3'd4;
   localparam logic [2:0] LD_HU = 3'd5;
   localparam logic [2:0] LD_WU = 3'd6;
   localparam logic [2:0] LD_INVALID = 3'd7;

   // Branch conditions (funct3)
   localparam logic [2:0] BR_EQ  = 3'd0;
   localparam logic [2:0] BR_NE  = 3'd1;
   localparam logic [2:0] BR_LT  = 3'd4;
   localparam logic [2:0] BR_GE  = 3'd5;
   localparam logic [2:0] BR_LTU = 3'd6;
   localparam logic [2:0] BR_GEU = 3'd7;

   localparam logic [2:0] ALU_ADD = 3'd0;
   localparam logic [2:0] ALU_SLL = 3'd1;
   localparam logic [2:0] ALU_SLT = 3'd2;
   localparam logic [2:0] ALU_SLTU = 3'd3;
   localparam logic [2:0] ALU_XOR = 3'd4;
   localparam logic [2:0] ALU_SR  = 3'd5;
   localparam logic [2:0] ALU_OR  = 3'd6;

   typedef enum logic [2:0] {
      ST_RETIRED = 3'd0,
      ST_READ    = 3'd1,
      ST_WRITE   = 3'd2,
      ST_FAULT   = 3'd3,
      ST_END     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_READ_A, S_READ_B, S_EXEC, S_MULDIV, S_FINISH
   } state_type;

   typedef struct packed {
      logic       start;
      logic [2:0] op;
   } md_req_type;

   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  mem_addr;
      logic [1:0]         size;
      logic [XLEN-1:0]    store;
      logic [XLEN-1:0]    new_pc;
      logic               wr;
      logic [REG_IDX_W-1:0] idx;
      logic [XLEN-1:0]    val;
      logic               set_load;
      logic               clr_load;
   } result_type;

endpackage

// ===== sv/rvis_ram.sv =====
// rvis_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rvis_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/rvis_muldiv.sv =====
// rvis_muldiv: iterative multiply/divide unit, one bit per cycle on a shared adder.
// Depends on rvis_pkg.
module rvis_muldiv (
   input  logic                  clock,
   input  logic                  reset,
   input  rvis_pkg::md_req_type  req,
   input  logic [63:0]           a,
   input  logic [63:0]           b,
   output logic                  done,
   output logic [63:0]           result
);

   logic         run_ff, run_in;
   logic         fin_ff, fin_in;
   logic         done_ff, done_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [2:0]   op_ff, op_in;
   logic [127:0] prod_ff, prod_in;
   logic [63:0]  dvs_ff, dvs_in;
   logic [63:0]  corr_ff, corr_in;
   logic         bz_ff, bz_in;
   logic         negq_ff, negq_in;
   logic         negr_ff, negr_in;
   logic [63:0]  res_ff, res_in;

   logic         is_mul;
   logic         sgn_div;
   logic [63:0]  abs_a, abs_b, ca, cb;
   logic [65:0]  add_x, add_y, add_s;
   logic         ge;
   logic [63:0]  hi, lo;

   assign is_mul = !op_ff[2];
   assign hi = prod_ff[127:64];
   assign lo = prod_ff[63:0];

   // shared adder: accumulate for multiply, trial subtract for divide
   always_comb begin
      add_x = is_mul ? {2'b00, hi} : {1'b0, prod_ff[127:63]};
      add_y = is_mul ? (prod_ff[0] ? {2'b00, dvs_ff} : 66'd0) : ~{2'b00, dvs_ff};
      add_s = add_x + add_y + {65'd0, !is_mul};
      ge = !add_s[65];
   end

   always_comb begin
      sgn_div = (req.op == rvis_pkg::MD_DIV) || (req.op == rvis_pkg::MD_REM);
      abs_a = (sgn_div && a[63]) ? (64'd0 - a) : a;
      abs_b = (sgn_div && b[63]) ? (64'd0 - b) : b;
      ca = a[63] ? b : 64'd0;
      cb = b[63] ? a : 64'd0;
   end

   always_comb begin
      run_in = run_ff; fin_in = 1'b0; done_in = 1'b0; cnt_in = cnt_ff; op_in = op_ff;
      prod_in = prod_ff; dvs_in = dvs_ff; corr_in = corr_ff; bz_in = bz_ff;
      negq_in = negq_ff; negr_in = negr_ff; res_in = res_ff;
      if (req.start) begin
         run_in = 1'b1;
         cnt_in = '1;
         op_in = req.op;
         prod_in = req.op[2] ? {64'd0, abs_a} : {64'd0, b};
         dvs_in = req.op[2] ? abs_b : a;
         bz_in = (b == 64'd0);
         negq_in = sgn_div && (a[63] ^ b[63]);
         negr_in = sgn_div && a[63];
         case (req.op)
            rvis_pkg::MD_MULH:   corr_in = ca + cb;
            rvis_pkg::MD_MULHSU: corr_in = ca;
            default:             corr_in = 64'd0;
         endcase
      end else if (run_ff) begin
         if (is_mul) begin
            prod_in = {add_s[64:0], prod_ff[63:1]};
         end else begin
            prod_in = {ge ? add_s[63:0] : prod_ff[126:63], prod_ff[62:0], ge};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         case (op_ff)
            rvis_pkg::MD_MUL:    res_in = lo;
            rvis_pkg::MD_MULH,
            rvis_pkg::MD_MULHSU: res_in = hi - corr_ff;
            rvis_pkg::MD_MULHU:  res_in = hi;
            rvis_pkg::MD_DIV:    res_in = bz_ff ? 64'd0 : (negq_ff ? 64'd0 - lo : lo);
            rvis_pkg::MD_DIVU:   res_in = bz_ff ? 64'd0 : lo;
            rvis_pkg::MD_REM:    res_in = bz_ff ? 64'd0 : (negr_ff ? 64'd0 - hi : hi);
            default:             res_in = bz_ff ? 64'd0 : hi;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in; op_ff <= op_in; prod_ff <= prod_in; dvs_ff <= dvs_in;
      corr_ff <= corr_in; bz_ff <= bz_in; negq_ff <= negq_in; negr_ff <= negr_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign result = res_ff;

endmodule

// ===== sv/rv64im_instruction_step.sv =====
// rv64im_instruction_step: one RV64IM instruction or load-data transaction per request.
// Instruction items read their source registers serially on one RAM port; load-data items
// go straight to execute; multiply/divide then waits on the 64-step shared unit.
// Throughput: one transaction at a time; req_tready is high only when the sequencer idles.
// Reset (synchronous, active high) clears pc, pending load, text-write enable and all
// register-file valid bits, so every register reads as zero until written.
module rv64im_instruction_step #(
   parameter logic [63:0] MEM_BYTES  = rvis_pkg::MEM_BYTES,
   parameter logic [63:0] DATA_START = rvis_pkg::DATA_START
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,  // instr_word[31:0], load_data[95:32]
   input  logic         req_tuser,  // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // mem_addr[17:0], access_size[19:18], store_value[83:20], new_pc[147:84],
   // dest_written[148], dest_index[153:149], dest_value[217:154], zero pad above
   output logic [223:0] rsp_tdata,
   output logic [2:0]   rsp_tuser,  // status
   input  logic         csr_write_enable,
   input  logic         csr_write_data
);

   rvis_pkg::state_type  state_ff, state_in;
   rvis_pkg::result_type res_ff, res_in, exec_res;
   rvis_pkg::md_req_type md_req;

   logic        kind_ff;
   logic [31:0] instr_ff;
   logic [63:0] ldata_ff;
   logic [63:0] a_ff;
   logic [4:0]  ridx_ff;
   logic [63:0] pc_ff;
   logic        pend_ff;
   logic [4:0]  pdest_ff;
   logic [2:0]  pkind_ff;
   logic        twe_ff;
   logic [31:0] vld_ff;
   logic        rsp_valid_ff;
   logic [223:0] rsp_data_ff;
   logic [2:0]  rsp_user_ff;

   logic [4:0]  raddr;
   logic        ren;
   logic        ram_we;
   logic [63:0] ram_rdata;
   logic [63:0] opnd;
   logic        slot_free;
   logic        md_done;
   logic [63:0] md_result;
   logic        md_go;

   // decoded fields
   logic [31:0] w;
   logic [6:0]  op, f7;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u, pc4, addr, ldv, b;
   logic        take;

   function automatic logic [63:0] alu(input logic [2:0] fn, input logic alt,
                                       input logic [63:0] x, input logic [63:0] y);
      logic [5:0] sh;
      begin
         sh = y[5:0];
         case (fn)
            rvis_pkg::ALU_ADD:  alu = alt ? x - y : x + y;
            rvis_pkg::ALU_SLL:  alu = x << sh;
            rvis_pkg::ALU_SLT:  alu = {63'd0, $signed(x) < $signed(y)};
            rvis_pkg::ALU_SLTU: alu = {63'd0, x < y};
            rvis_pkg::ALU_XOR:  alu = x ^ y;
            rvis_pkg::ALU_SR:   alu = alt ? 64'($signed(x) >>> sh) : x >> sh;
            rvis_pkg::ALU_OR:   alu = x | y;
            default:            alu = x & y;
         endcase
      end
   endfunction

   // access past the end of memory, computed without wrap
   function automatic logic addr_bad(input logic [63:0] ad, input logic [1:0] sz);
      begin
         addr_bad = ad > (MEM_BYTES - (64'd1 << sz));
      end
   endfunction

   rvis_ram #(.WIDTH(rvis_pkg::XLEN), .DEPTH(rvis_pkg::REG_COUNT)) u_regs (
      .clock (clock),
      .we    (ram_we),
      .waddr (res_ff.idx),
      .wdata (res_ff.val),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   rvis_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .req    (md_req),
      .a      (a_ff),
      .b      (b),
      .done   (md_done),
      .result (md_result)
   );

   // registers never written read as zero
   assign opnd = vld_ff[ridx_ff] ? ram_rdata : 64'd0;
   assign b = opnd;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      w = instr_ff;
      op = w[6:0];
      rd = w[11:7];
      f3 = w[14:12];
      f7 = w[31:25];
      imm_i = {{52{w[31]}}, w[31:20]};
      imm_s = {{52{w[31]}}, w[31:25], w[11:7]};
      imm_b = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      imm_j = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      imm_u = {{32{w[31]}}, w[31:12], 12'd0};
      pc4 = pc_ff + 64'd4;
      addr = a_ff + ((op == rvis_pkg::OP_STORE) ? imm_s : imm_i);
      case (pkind_ff)
         rvis_pkg::LD_B:  ldv = {{56{ldata_ff[7]}}, ldata_ff[7:0]};
         rvis_pkg::LD_H:  ldv = {{48{ldata_ff[15]}}, ldata_ff[15:0]};
         rvis_pkg::LD_W:  ldv = {{32{ldata_ff[31]}}, ldata_ff[31:0]};
         rvis_pkg::LD_BU: ldv = {56'd0, ldata_ff[7:0]};
         rvis_pkg::LD_HU: ldv = {48'd0, ldata_ff[15:0]};
         rvis_pkg::LD_WU: ldv = {32'd0, ldata_ff[31:0]};
         default:         ldv = ldata_ff;
      endcase
      case (f3)
         rvis_pkg::BR_EQ:  take = (a_ff == b);
         rvis_pkg::BR_NE:  take = (a_ff != b);
         rvis_pkg::BR_LT:  take = $signed(a_ff) < $signed(b);
         rvis_pkg::BR_GE:  take = !($signed(a_ff) < $signed(b));
         rvis_pkg::BR_LTU: take = a_ff < b;
         rvis_pkg::BR_GEU: take = a_ff >= b;
         default:          take = 1'b0;
      endcase
   end

   // execute: work out the whole response from the latched transaction
   always_comb begin
      exec_res = '0;
      exec_res.status = rvis_pkg::ST_RETIRED;
      exec_res.new_pc = pc_ff;
      md_go = 1'b0;
      if (kind_ff) begin
         if (!pend_ff) begin
            exec_res.status = rvis_pkg::ST_FAULT;
         end else begin
            exec_res.clr_load = 1'b1;
            exec_res.wr = (pdest_ff != 5'd0);
            exec_res.idx = exec_res.wr ? pdest_ff : 5'd0;
            exec_res.val = exec_res.wr ? ldv : 64'd0;
         end
      end else if (pend_ff || (pc_ff > DATA_START - 64'd4)) begin
         exec_res.status = rvis_pkg::ST_FAULT;
      end else if (w == 32'd0) begin
         exec_res.status = rvis_pkg::ST_END;
      end else begin
         exec_res.new_pc = pc4;
         case (op)
            rvis_pkg::OP_REG: begin
               if (f7 == rvis_pkg::F7_BASE ||
                   (f7 == rvis_pkg::F7_ALT && (f3 == rvis_pkg::ALU_ADD || f3 == rvis_pkg::ALU_SR))) begin
                  exec_res.wr = 1'b1;
                  exec_res.val = alu(f3, f7 == rvis_pkg::F7_ALT, a_ff, b);
               end else if (f7 == rvis_pkg::F7_MULD) begin
                  exec_res.wr = 1'b1;
                  md_go = 1'b1;
               end
            end
            rvis_pkg::OP_IMM: begin
               exec_res.wr = 1'b1;
               exec_res.val = alu(f3, (f3 == rvis_pkg::ALU_SR) && w[30], a_ff, imm_i);
            end
            rvis_pkg::OP_LOAD: begin
               if (f3 != rvis_pkg::LD_INVALID) begin
                  if (addr_bad(addr, f3[1:0])) begin
                     exec_res.status = rvis_pkg::ST_FAULT;
                     exec_res.new_pc = pc_ff;
                  end else begin
                     exec_res.status = rvis_pkg::ST_READ;
                     exec_res.mem_addr = addr[rvis_pkg::ADDR_W-1:0];
                     exec_res.size = f3[1:0];
                     exec_res.set_load = 1'b1;
                  end
               end
            end
            rvis_pkg::OP_STORE: begin
               if (!f3[2]) begin
                  if (addr_bad(addr, f3[1:0]) || (!twe_ff && addr < DATA_START)) begin
                     exec_res.status = rvis_pkg::ST_FAULT;
                     exec_res.new_pc = pc_ff;
                  end else begin
                     exec_res.status = rvis_pkg::ST_WRITE;
                     exec_res.mem_addr = addr[rvis_pkg::ADDR_W-1:0];
                     exec_res.size = f3[1:0];
                     case (f3[1:0])
                        2'd0:    exec_res.store = {56'd0, b[7:0]};
                        2'd1:    exec_res.store = {48'd0, b[15:0]};
                        2'd2:    exec_res.store = {32'd0, b[31:0]};
                        default: exec_res.store = b;
                     endcase
                  end
               end
            end
            rvis_pkg::OP_BRANCH: begin
               if (take) begin
                  exec_res.new_pc = pc_ff + imm_b;
               end
            end
            rvis_pkg::OP_JAL: begin
               exec_res.wr = 1'b1;
               exec_res.val = pc4;
               exec_res.new_pc = pc_ff + imm_j;
            end
            rvis_pkg::OP_JALR: begin
               if (f3 == 3'd0) begin
                  exec_res.wr = 1'b1;
                  exec_res.val = pc4;
                  exec_res.new_pc = (a_ff + imm_i) & ~64'd1;
               end
            end
            rvis_pkg::OP_LUI: begin
               exec_res.wr = 1'b1;
               exec_res.val = imm_u;
            end
            rvis_pkg::OP_AUIPC: begin
               exec_res.wr = 1'b1;
               exec_res.val = pc_ff + imm_u;
            end
            default: begin
               exec_res.wr = 1'b0;
            end
         endcase
         // drop writes to x0
         if (rd == 5'd0) begin
            exec_res.wr = 1'b0;
         end
         exec_res.idx = exec_res.wr ? rd : 5'd0;
         if (!exec_res.wr) begin
            exec_res.val = 64'd0;
         end
      end
   end

   always_comb begin
      res_in = res_ff;
      if (state_ff == rvis_pkg::S_EXEC) begin
         res_in = exec_res;
      end else if (state_ff == rvis_pkg::S_MULDIV && md_done && res_ff.wr) begin
         res_in.val = md_result;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rvis_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = req_tuser ? rvis_pkg::S_EXEC : rvis_pkg::S_READ_A;
            end
         end
         rvis_pkg::S_READ_A: state_in = rvis_pkg::S_READ_B;
         rvis_pkg::S_READ_B: state_in = rvis_pkg::S_EXEC;
         rvis_pkg::S_EXEC:   state_in = md_go ? rvis_pkg::S_MULDIV : rvis_pkg::S_FINISH;
         rvis_pkg::S_MULDIV: begin
            if (md_done) begin
               state_in = rvis_pkg::S_FINISH;
            end
         end
         rvis_pkg::S_FINISH: begin
            if (slot_free) begin
               state_in = rvis_pkg::S_IDLE;
            end
         end
         default: state_in = rvis_pkg::S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      ren = 1'b0;
      raddr = ridx_ff;
      ram_we = 1'b0;
      md_req = '0;
      case (state_ff)
         rvis_pkg::S_IDLE: req_tready = 1'b1;
         rvis_pkg::S_READ_A: begin
            ren = 1'b1;
            raddr = w[19:15];
         end
         rvis_pkg::S_READ_B: begin
            ren = 1'b1;
            raddr = w[24:20];
         end
         rvis_pkg::S_EXEC: begin
            md_req.start = md_go;
            md_req.op = f3;
         end
         rvis_pkg::S_FINISH: ram_we = slot_free && res_ff.wr;
         default: req_tready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rvis_pkg::S_IDLE;
         pc_ff <= 64'd0;
         pend_ff <= 1'b0;
         pdest_ff <= 5'd0;
         pkind_ff <= 3'd0;
         twe_ff <= 1'b0;
         vld_ff <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            twe_ff <= csr_write_data;
         end
         if (state_ff == rvis_pkg::S_FINISH && slot_free) begin
            // commit architectural state and present the response
            rsp_valid_ff <= 1'b1;
            pc_ff <= res_ff.new_pc;
            if (res_ff.set_load) begin
               pend_ff <= 1'b1;
               pdest_ff <= rd;
               pkind_ff <= f3;
            end else if (res_ff.clr_load) begin
               pend_ff <= 1'b0;
            end
            if (res_ff.wr) begin
               vld_ff[res_ff.idx] <= 1'b1;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_tvalid && req_tready) begin
         kind_ff <= req_tuser;
         instr_ff <= req_tdata[31:0];
         ldata_ff <= req_tdata[95:32];
      end
      if (ren) begin
         ridx_ff <= raddr;
      end
      if (state_ff == rvis_pkg::S_READ_B) begin
         a_ff <= opnd;
      end
      res_ff <= res_in;
      if (state_ff == rvis_pkg::S_FINISH && slot_free) begin
         rsp_user_ff <= res_ff.status;
         rsp_data_ff <= {6'd0, res_ff.val, res_ff.idx, res_ff.wr, res_ff.new_pc,
                         res_ff.store, res_ff.size, res_ff.mem_addr};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

`ifndef NO_ASSERTIONS
   // a new transaction is never taken while the multiply/divide unit is in flight
   a_no_accept_in_md: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rvis_pkg::S_MULDIV) |-> !req_tready)
      else $error("request accepted during multiply/divide");

   // a pending load is only ever raised by a read-request response
   a_load_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(pend_ff) |-> (rsp_tvalid && rsp_tuser == rvis_pkg::ST_READ))
      else $error("load pending without read request");

   // pc changes only at commit
   a_pc_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != rvis_pkg::S_FINISH) |=> $stable(pc_ff))
      else $error("pc moved outside commit");

   // register writes carry a non-zero index
   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (res_ff.idx != 5'd0))
      else $error("write to x0");
`endif

endmodule

// ===== test/rv64im_instruction_step_tb.sv =====
// Self-checking testbench for rv64im_instruction_step: instruction and load-data
// transactions in, one status/result transaction out per request, checked against a
// behavioural predictor kept here. Depends on rvis_pkg and the block itself.
module rv64im_instruction_step_tb;
   import rvis_pkg::*;

   localparam int  HALF_PERIOD = 6;
   localparam int  STALL_LIMIT = 4000;   // cycles with no transaction on either side
   localparam int  IDLE_PCT    = 28;
   localparam logic [63:0] FETCH_MAX = DATA_START - 64'd4;

   typedef struct {
      status_type   status;
      logic [17:0]  mem_addr;
      logic [1:0]   size;
      logic [63:0]  store;
      logic [63:0]  new_pc;
      logic         wr;
      logic [4:0]   idx;
      logic [63:0]  val;
   } outcome_t;

   typedef struct {
      logic         is_data;
      logic [31:0]  word;
      logic [63:0]  data;
      outcome_t     outcome;
   } request_t;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [95:0]   req_tdata = '0;   // instr_word[31:0], load_data[95:32]
   logic          req_tuser = 1'b0; // req_type
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [223:0]  rsp_tdata;        // mem_addr, access_size, store_value, new_pc,
                                    // dest_written, dest_index, dest_value, pad
   logic [2:0]    rsp_tuser;        // status
   logic          csr_write_enable = 1'b0;
   logic          csr_write_data = 1'b0;

   // Architectural shadow of the core
   logic [63:0]   xreg [32];
   logic [63:0]   pc_q;
   logic          load_busy;
   logic [4:0]    load_rd;
   logic [2:0]    load_kind;
   logic          text_we;

   request_t      stim_q [$];
   outcome_t      outcome_q [$];
   request_t      in_flight;
   logic          req_taken = 1'b0;
   bit            calm = 1'b0;      // suppress idling on both sides
   int            n_issued = 0;
   int            n_resp = 0;
   int            n_errors = 0;
   int            stall_cnt = 0;
   int            n_reads = 0, n_writes = 0, n_faults = 0;

   rv64im_instruction_step DUT (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------- encoders
   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, OP_REG};
   endfunction

   function automatic logic [31:0] enc_i(logic [11:0] im, logic [4:0] rs1, logic [2:0] f3,
                                         logic [4:0] rd, logic [6:0] op);
      return {im, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_s(logic [11:0] im, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {im[11:5], rs2, rs1, f3, im[4:0], OP_STORE};
   endfunction

   function automatic logic [31:0] enc_b(logic [12:0] o, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {o[12], o[10:5], rs2, rs1, f3, o[4:1], o[11], OP_BRANCH};
   endfunction

   function automatic logic [31:0] enc_j(logic [20:0] o, logic [4:0] rd);
      return {o[20], o[10:1], o[11], o[19:12], rd, OP_JAL};
   endfunction

   function automatic logic [31:0] enc_u(logic [19:0] up, logic [4:0] rd, logic [6:0] op);
      return {up, rd, op};
   endfunction

   // ---------------------------------------------------------------- predictor
   function automatic void put_dest(ref outcome_t o, input logic [4:0] rd,
                                    input logic [63:0] v);
      if (rd != 5'd0) begin
         xreg[rd] = v;
         o.wr  = 1'b1;
         o.idx = rd;
         o.val = v;
      end
   endfunction

   function automatic logic addr_out_of_range(logic [63:0] addr, logic [1:0] sz);
      return addr > (MEM_BYTES - (64'd1 << sz));
   endfunction

   function automatic logic [63:0] alu_op(logic [2:0] f3, logic sub_or_sra,
                                          logic [63:0] a, logic [63:0] b);
      case (f3)
         ALU_ADD:  return a + b;
         ALU_SLL:  return a << b[5:0];
         ALU_SLT:  return ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
         ALU_SLTU: return (a < b) ? 64'd1 : 64'd0;
         ALU_XOR:  return a ^ b;
         ALU_SR:   return sub_or_sra ? 64'($signed(a) >>> b[5:0]) : a >> b[5:0];
         ALU_OR:   return a | b;
         default:  return a & b;
      endcase
   endfunction

   function automatic logic [63:0] muldiv_op(logic [2:0] f3, logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      logic signed [63:0] sa, sb;
      logic [63:0] most_neg;
      sa = a;
      sb = b;
      most_neg = 64'h8000_0000_0000_0000;
      case (f3)
         MD_MUL:    return a * b;
         MD_MULH: begin
            prod = {{64{a[63]}}, a} * {{64{b[63]}}, b};
            return prod[127:64];
         end
         MD_MULHSU: begin
            prod = {{64{a[63]}}, a} * {64'd0, b};
            return prod[127:64];
         end
         MD_MULHU: begin
            prod = {64'd0, a} * {64'd0, b};
            return prod[127:64];
         end
         MD_DIV: begin
            if (b == 64'd0) return 64'd0;
            if (a == most_neg && b == '1) return most_neg;
            return 64'(sa / sb);
         end
         MD_DIVU:   return (b == 64'd0) ? 64'd0 : a / b;
         MD_REM: begin
            if (b == 64'd0 || (a == most_neg && b == '1)) return 64'd0;
            return 64'(sa % sb);
         end
         default:   return (b == 64'd0) ? 64'd0 : a % b;
      endcase
   endfunction

   // Advance the shadow core by one transaction and return what it should report.
   function automatic outcome_t core_step(logic is_data, logic [31:0] w, logic [63:0] ld);
      outcome_t o;
      logic [63:0] a, b, imm, addr, v, nxt;
      logic [6:0] op, f7;
      logic [2:0] f3;
      logic [4:0] rd;
      logic take;
      o = '{status: ST_RETIRED, mem_addr: '0, size: '0, store: '0, new_pc: pc_q,
            wr: 1'b0, idx: '0, val: '0};
      if (is_data) begin
         if (!load_busy) begin
            o.status = ST_FAULT;
            return o;
         end
         case (load_kind)
            LD_B:    v = {{56{ld[7]}}, ld[7:0]};
            LD_H:    v = {{48{ld[15]}}, ld[15:0]};
            LD_W:    v = {{32{ld[31]}}, ld[31:0]};
            LD_BU:   v = {56'd0, ld[7:0]};
            LD_HU:   v = {48'd0, ld[15:0]};
            LD_WU:   v = {32'd0, ld[31:0]};
            default: v = ld;
         endcase
         load_busy = 1'b0;
         put_dest(o, load_rd, v);
         return o;
      end
      if (load_busy || pc_q > FETCH_MAX) begin
         o.status = ST_FAULT;
         return o;
      end
      if (w == 32'd0) begin
         o.status = ST_END;
         return o;
      end
      op  = w[6:0];
      rd  = w[11:7];
      f3  = w[14:12];
      f7  = w[31:25];
      a   = xreg[w[19:15]];
      b   = xreg[w[24:20]];
      imm = {{52{w[31]}}, w[31:20]};
      nxt = pc_q + 64'd4;
      case (op)
         OP_REG: begin
            if (f7 == F7_BASE)
               put_dest(o, rd, alu_op(f3, 1'b0, a, b));
            else if (f7 == F7_ALT && f3 == ALU_ADD)
               put_dest(o, rd, a - b);
            else if (f7 == F7_ALT && f3 == ALU_SR)
               put_dest(o, rd, alu_op(f3, 1'b1, a, b));
            else if (f7 == F7_MULD)
               put_dest(o, rd, muldiv_op(f3, a, b));
         end
         OP_IMM: put_dest(o, rd, alu_op(f3, w[30], a, imm));
         OP_LOAD: begin
            if (f3 != LD_INVALID) begin
               addr = a + imm;
               if (addr_out_of_range(addr, f3[1:0])) begin
                  o.status = ST_FAULT;
                  return o;
               end
               load_busy  = 1'b1;
               load_rd    = rd;
               load_kind  = f3;
               o.status   = ST_READ;
               o.mem_addr = addr[17:0];
               o.size     = f3[1:0];
            end
         end
         OP_STORE: begin
            if (f3 <= 3'd3) begin
               addr = a + {{52{w[31]}}, w[31:25], w[11:7]};
               if (addr_out_of_range(addr, f3[1:0]) || (!text_we && addr < DATA_START)) begin
                  o.status = ST_FAULT;
                  return o;
               end
               o.status   = ST_WRITE;
               o.mem_addr = addr[17:0];
               o.size     = f3[1:0];
               o.store    = (f3 == 3'd3) ? b : b & ((64'd1 << (8 << f3)) - 64'd1);
            end
         end
         OP_BRANCH: begin
            imm = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            case (f3)
               BR_EQ:   take = (a == b);
               BR_NE:   take = (a != b);
               BR_LT:   take = ($signed(a) < $signed(b));
               BR_GE:   take = !($signed(a) < $signed(b));
               BR_LTU:  take = (a < b);
               BR_GEU:  take = (a >= b);
               default: take = 1'b0;
            endcase
            if (take) nxt = pc_q + imm;
         end
         OP_JAL: begin
            imm = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            put_dest(o, rd, pc_q + 64'd4);
            nxt = pc_q + imm;
         end
         OP_JALR: begin
            if (f3 == 3'd0) begin
               v = (a + imm) & ~64'd1;
               put_dest(o, rd, pc_q + 64'd4);
               nxt = v;
            end
         end
         OP_LUI:   put_dest(o, rd, {{32{w[31]}}, w[31:12], 12'd0});
         OP_AUIPC: put_dest(o, rd, pc_q + {{32{w[31]}}, w[31:12], 12'd0});
         default: ;
      endcase
      pc_q     = nxt;
      o.new_pc = nxt;
      return o;
   endfunction

   // Queue a transaction with its predicted outcome.
   task automatic issue(logic is_data, logic [31:0] w, logic [63:0] ld);
      request_t r;
      r.is_data = is_data;
      r.word    = w;
      r.data    = ld;
      r.outcome = core_step(is_data, w, ld);
      stim_q.push_back(r);
      n_issued++;
   endtask

   // Issue an instruction, but replace it by a jump back into low text if it would
   // carry the pc out of the fetchable region (the core could never recover).
   task automatic issue_instr(logic [31:0] w);
      logic [63:0] saved_regs [32];
      logic [63:0] saved_pc, target;
      logic saved_busy;
      logic [4:0] saved_rd;
      logic [2:0] saved_kind;
      outcome_t peek;
      saved_regs = xreg;
      saved_pc   = pc_q;
      saved_busy = load_busy;
      saved_rd   = load_rd;
      saved_kind = load_kind;
      peek = core_step(1'b0, w, 64'd0);
      xreg      = saved_regs;
      pc_q      = saved_pc;
      load_busy = saved_busy;
      load_rd   = saved_rd;
      load_kind = saved_kind;
      if (peek.new_pc > FETCH_MAX) begin
         target = 64'($urandom_range(0, 4000)) * 64'd4;
         w = enc_j(21'(target - pc_q), 5'($urandom));
      end
      issue(1'b0, w, 64'd0);
   endtask

   function automatic logic [4:0] mem_base();
      return ($urandom_range(0, 1) != 0) ? 5'd0 : 5'(28 + $urandom_range(0, 3));
   endfunction

   function automatic logic [31:0] random_word();
      logic [4:0] rd, rs1, rs2;
      logic [2:0] f3;
      logic [11:0] im;
      logic [6:0] f7;
      int k;
      rd  = 5'($urandom);
      rs1 = 5'($urandom);
      rs2 = 5'($urandom);
      f3  = 3'($urandom);
      im  = 12'($urandom);
      k   = $urandom_range(0, 99);
      if (k < 22) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: f7 = F7_MULD;
            4, 5, 6:    f7 = F7_BASE;
            7, 8:       f7 = F7_ALT;
            default:    f7 = 7'($urandom);
         endcase
         return enc_r(f7, rs2, rs1, f3, rd);
      end
      if (k < 40) return enc_i(im, rs1, f3, rd, OP_IMM);
      if (k < 52) return enc_i(im, mem_base(), f3, rd, OP_LOAD);
      if (k < 64) begin
         if ($urandom_range(0, 3) != 0) f3[2] = 1'b0;
         return enc_s(im, rs2, mem_base(), f3);
      end
      if (k < 74) return enc_b(13'($urandom_range(0, 256)) * 13'd2 - 13'd256, rs2, rs1, f3);
      if (k < 79) return enc_j(21'($urandom_range(0, 512)) * 21'd4 - 21'd1024, rd);
      if (k < 84) begin
         if ($urandom_range(0, 4) != 0) f3 = 3'd0;
         return enc_i({1'b0, im[10:0]}, 5'd0, f3, rd, OP_JALR);
      end
      if (k < 88) begin
         if ($urandom_range(0, 1) != 0)
            return enc_u(20'($urandom_range(0, 63)), 5'(28 + $urandom_range(0, 3)), OP_LUI);
         return enc_u(20'($urandom), rd, OP_LUI);
      end
      if (k < 91) return enc_u(20'($urandom), rd, OP_AUIPC);
      if (k < 94) return {25'($urandom), 7'h73};
      if (k < 98) return $urandom;
      return 32'd0;
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         if (load_busy) begin
            // mostly complete the load; now and then push an instruction into it
            if ($urandom_range(0, 99) < 85) issue(1'b1, $urandom, {$urandom, $urandom});
            else issue(1'b0, random_word(), 64'd0);
         end else if ($urandom_range(0, 99) < 3) begin
            issue(1'b1, $urandom, {$urandom, $urandom});
         end else begin
            issue_instr(random_word());
         end
      end
   endtask

   // Hold the sender off until every predicted response has come back.
   task automatic drain();
      while (n_resp < n_issued) @(negedge clock);
   endtask

   task automatic write_text_enable(logic v);
      drain();
      repeat (8) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      text_we = v;
   endtask

   // ---------------------------------------------------------------- driver
   // Present the next transaction at the falling edge once the previous one has gone.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (stim_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            in_flight = stim_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {in_flight.data, in_flight.word};
            req_tuser  <= in_flight.is_data;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
   end

   // ---------------------------------------------------------------- monitor
   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
         n_errors++;
      end
   endfunction

   always @(posedge clock) begin
      outcome_t e;
      if (!reset) begin
         req_taken <= req_tvalid && req_tready;
         // Check responses before queueing this edge's request: a response can
         // never belong to a transaction accepted at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            n_resp++;
            if (outcome_q.size() == 0) begin
               $display("%0t: response with no transaction outstanding, status %0d",
                        $time, rsp_tuser);
               n_errors++;
            end else begin
               e = outcome_q.pop_front();
               check_field("status", 64'(e.status), 64'(rsp_tuser));
               check_field("mem_addr", 64'(e.mem_addr), 64'(rsp_tdata[17:0]));
               check_field("access_size", 64'(e.size), 64'(rsp_tdata[19:18]));
               check_field("store_value", e.store, rsp_tdata[83:20]);
               check_field("new_pc", e.new_pc, rsp_tdata[147:84]);
               check_field("dest_written", 64'(e.wr), 64'(rsp_tdata[148]));
               check_field("dest_index", 64'(e.idx), 64'(rsp_tdata[153:149]));
               check_field("dest_value", e.val, rsp_tdata[217:154]);
               case (e.status)
                  ST_READ:  n_reads++;
                  ST_WRITE: n_writes++;
                  ST_FAULT: n_faults++;
                  default: ;
               endcase
            end
         end
         if (req_tvalid && req_tready) outcome_q.push_back(in_flight.outcome);
         // Watchdog: any transaction on either side clears it.
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cnt <= 0;
         end else if (stall_cnt >= STALL_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end else begin
            stall_cnt <= stall_cnt + 1;
         end
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      foreach (xreg[i]) xreg[i] = 64'd0;
      pc_q      = 64'd0;
      load_busy = 1'b0;
      load_rd   = 5'd0;
      load_kind = 3'd0;
      text_we   = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_text_enable(1'b0);

      // Directed: value extremes, M-unit corner cases, memory bounds and protection
      issue(1'b0, enc_u(20'h80000, 5'd1, OP_LUI), 64'd0);
      issue(1'b0, enc_i(12'hFFF, 5'd0, ALU_ADD, 5'd2, OP_IMM), 64'd0);
      issue(1'b0, enc_i(12'd1, 5'd0, ALU_ADD, 5'd3, OP_IMM), 64'd0);
      issue(1'b0, enc_i(12'd63, 5'd3, ALU_SLL, 5'd3, OP_IMM), 64'd0);
      issue(1'b0, enc_r(F7_MULD, 5'd2, 5'd3, MD_DIV, 5'd4), 64'd0);   // overflow
      issue(1'b0, enc_r(F7_MULD, 5'd2, 5'd3, MD_REM, 5'd5), 64'd0);
      issue(1'b0, enc_r(F7_MULD, 5'd0, 5'd2, MD_DIV, 5'd6), 64'd0);   // divide by zero
      issue(1'b0, enc_r(F7_MULD, 5'd0, 5'd2, MD_DIVU, 5'd6), 64'd0);
      issue(1'b0, enc_r(F7_MULD, 5'd0, 5'd3, MD_REM, 5'd7), 64'd0);
      issue(1'b0, enc_r(F7_MULD, 5'd0, 5'd2, MD_REMU, 5'd7), 64'd0);
      issue(1'b0, enc_r(F7_MULD, 5'd2, 5'd3, MD_MULH, 5'd8), 64'd0);
      issue(1'b0, enc_r(F7_MULD, 5'd2, 5'd2, MD_MULHSU, 5'd9), 64'd0);
      issue(1'b0, enc_r(F7_MULD, 5'd2, 5'd2, MD_MULHU, 5'd10), 64'd0);
      issue(1'b0, enc_i({6'b010000, 6'd63}, 5'd3, ALU_SR, 5'd11, OP_IMM), 64'd0);
      issue(1'b0, enc_r(F7_ALT, 5'd2, 5'd3, ALU_SR, 5'd12), 64'd0);
      issue(1'b0, enc_u(20'hFFFFF, 5'd13, OP_AUIPC), 64'd0);
      issue(1'b0, enc_u(20'h00010, 5'd15, OP_LUI), 64'd0);            // data base
      issue(1'b0, enc_u(20'h00040, 5'd16, OP_LUI), 64'd0);            // memory top
      issue(1'b0, enc_s(12'd0, 5'd2, 5'd15, 3'd3), 64'd0);            // sd at data base
      issue(1'b0, enc_s(12'hFFF, 5'd2, 5'd15, 3'd0), 64'd0);          // sb into text
      issue(1'b0, enc_i(12'hFF8, 5'd16, 3'd3, 5'd17, OP_LOAD), 64'd0); // last doubleword
      issue(1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      issue(1'b0, enc_i(12'hFFE, 5'd16, LD_W, 5'd18, OP_LOAD), 64'd0); // runs past top
      issue(1'b0, enc_i(12'd0, 5'd15, LD_BU, 5'd0, OP_LOAD), 64'd0);  // load to x0
      issue(1'b0, enc_r(F7_BASE, 5'd1, 5'd1, ALU_ADD, 5'd1), 64'd0);  // while pending
      issue(1'b1, 32'd0, 64'h0000_0000_0000_00A5);
      issue(1'b1, 32'd0, 64'd0);                                      // nothing pending
      issue(1'b0, 32'd0, 64'd0);                                      // end of code
      issue(1'b0, 32'h0000_0073, 64'd0);                              // ecall
      issue(1'b0, 32'h0000_0F7B, 64'd0);                              // unknown opcode
      issue(1'b0, enc_i(12'd1, 5'd0, 3'd0, 5'd19, OP_JALR), 64'd0);   // bit 0 cleared
      issue(1'b0, enc_j(21'd65532, 5'd20), 64'd0);                    // last fetchable word
      issue(1'b0, enc_j(-21'sd65532, 5'd0), 64'd0);

      write_text_enable(1'b1);
      random_phase(420);

      // Run flat out on both sides for one whole phase.
      write_text_enable(1'b0);
      calm = 1'b1;
      random_phase(400);
      drain();
      calm = 1'b0;

      write_text_enable(1'b1);
      random_phase(420);
      if (load_busy) issue(1'b1, $urandom, {$urandom, $urandom});

      // Leave the text region for good: fetch faults from here on.
      issue(1'b0, enc_u(20'h00010, 5'd21, OP_LUI), 64'd0);
      issue(1'b0, enc_i(12'd0, 5'd21, 3'd0, 5'd0, OP_JALR), 64'd0);
      issue(1'b0, random_word() | 32'h1, 64'd0);
      issue(1'b1, 32'd0, {$urandom, $urandom});

      drain();
      repeat (80) @(posedge clock);
      $display("Ran %0d transactions: %0d read requests, %0d write requests, %0d faults,",
               n_issued, n_reads, n_writes, n_faults);
      $display("text write enable toggled across four phases, one without back-pressure.");
      if (n_errors == 0 && outcome_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (outcome_q.size() != 0)
            $display("%0d responses never arrived", outcome_q.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== rv64im_instruction_step.f =====
sv/rvis_pkg.sv
sv/rvis_ram.sv
sv/rvis_muldiv.sv
sv/rv64im_instruction_step.sv
test/rv64im_instruction_step_tb.sv
